/* rtl/htfd_pkg.sv */
// Package for the humidity and temperature frame decoder.
// Holds the status codes, the CRC-8 constants and step function, and the scaling constants.
// No dependencies.
package htfd_pkg;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_CRC = 2'd1,
		STATUS_HUM_CRC  = 2'd2
	} status_t;

	localparam logic [7:0]  CRC_POLY          = 8'h31;
	localparam logic [7:0]  CRC_INIT          = 8'hFF;
	localparam logic [15:0] FULL_SCALE        = 16'hFFFF;
	localparam logic [14:0] TEMP_SPAN_CENTI   = 15'd17500;
	localparam logic [14:0] TEMP_OFFSET_CENTI = 15'd4500;
	localparam logic [13:0] HUM_SPAN_CENTI    = 14'd10000;
	localparam int          TEMP_MIN_CENTI    = -4500;
	localparam int          TEMP_MAX_CENTI    = 13000;

	localparam int          FRAME_BYTES       = 6;
	localparam logic [2:0]  POS_LAST          = 3'(FRAME_BYTES - 1);

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/humidity_temp_frame_decoder.sv */
// Top level of the humidity and temperature frame decoder: CRC check and fixed-point scaling.
// Depends on htfd_pkg.
// Results are registered from the sixth byte in the input register. Throughput: one byte per
// cycle unless a sixth byte meets an unread result; the input and result registers each take
// one request per cycle, and the result register lets the next bytes in while it waits.
// Reset (arst_n low, asynchronous): frame position 0, CRC 0xFF, stored values zero, no result.
module humidity_temp_frame_decoder
	import htfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [1:0] status, [16:2] temperature_centi, [30:17] humidity_centi
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic        temp_bad_q;
	logic [7:0]  temp_hi_q;
	logic [7:0]  hum_hi_q;
	logic [30:0] temp_prod_q;
	logic [29:0] hum_prod_q;
	logic [14:0] last_temp_q;
	logic [13:0] last_hum_q;

	logic        m_tvalid_q;
	status_t     status_q;
	logic [14:0] temp_out_q;
	logic [13:0] hum_out_q;

	logic [2:0]  pos_eff;
	logic        last_byte;
	logic        advance;
	logic [7:0]  crc_next;
	logic [7:0]  crc_seed;
	status_t     status_d;
	logic [16:0] temp_sum;
	logic [16:0] hum_sum;
	logic [14:0] temp_quot;
	logic [13:0] hum_quot;
	logic [14:0] temp_new;

	always_comb begin
		pos_eff   = (start_s1 || pos_q > POS_LAST) ? 3'd0 : pos_q;
		last_byte = valid_s1 && (pos_eff == POS_LAST);
		advance   = valid_s1 && (!last_byte || !m_tvalid_q || m_tready);
		s_tready  = !valid_s1 || advance;

		crc_seed  = (pos_eff == 3'd0 || pos_eff == 3'd3) ? CRC_INIT : crc_q;
		crc_next  = crc8_byte(crc_seed, byte_s1);

		// divide by 2^16-1: q = hi + ((hi + lo) >= 2^16-1)
		temp_sum  = 17'(temp_prod_q[30:16]) + 17'(temp_prod_q[15:0]);
		hum_sum   = 17'(hum_prod_q[29:16]) + 17'(hum_prod_q[15:0]);
		temp_quot = temp_prod_q[30:16] + 15'(temp_sum >= 17'(FULL_SCALE));
		hum_quot  = hum_prod_q[29:16] + 14'(hum_sum >= 17'(FULL_SCALE));
		temp_new  = temp_quot - TEMP_OFFSET_CENTI;

		priority if (temp_bad_q) begin
			status_d = STATUS_TEMP_CRC;
		end else if (byte_s1 != crc_q) begin
			status_d = STATUS_HUM_CRC;
		end else begin
			status_d = STATUS_OK;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 3'd0;
			crc_q       <= CRC_INIT;
			temp_bad_q  <= 1'b0;
			last_temp_q <= 15'd0;
			last_hum_q  <= 14'd0;
		end else if (advance) begin
			unique case (pos_eff)
				3'd0, 3'd1, 3'd3, 3'd4: begin
					crc_q <= crc_next;
					pos_q <= pos_eff + 3'd1;
				end
				3'd2: begin
					temp_bad_q <= (byte_s1 != crc_q);
					crc_q      <= CRC_INIT;
					pos_q      <= 3'd3;
				end
				default: begin
					if (status_d == STATUS_OK) begin
						last_temp_q <= temp_new;
						last_hum_q  <= hum_quot;
					end
					crc_q <= CRC_INIT;
					pos_q <= 3'd0;
				end
			endcase
		end
	end

	// raw words and their scaled products
	always_ff @(posedge clk) begin
		if (advance) begin
			if (pos_eff == 3'd0) begin
				temp_hi_q <= byte_s1;
			end
			if (pos_eff == 3'd1) begin
				temp_prod_q <= 31'(TEMP_SPAN_CENTI) * 31'({temp_hi_q, byte_s1});
			end
			if (pos_eff == 3'd3) begin
				hum_hi_q <= byte_s1;
			end
			if (pos_eff == 3'd4) begin
				hum_prod_q <= 30'(HUM_SPAN_CENTI) * 30'({hum_hi_q, byte_s1});
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (last_byte && advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_byte && advance) begin
			status_q <= status_d;
			if (status_d == STATUS_OK) begin
				temp_out_q <= temp_new;
				hum_out_q  <= hum_quot;
			end else begin
				temp_out_q <= last_temp_q;
				hum_out_q  <= last_hum_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, hum_out_q, temp_out_q, status_q};

endmodule

/* rtl/htfd_checker.sv */
// Port-level checker for the humidity and temperature frame decoder, and its bind.
// Depends on htfd_pkg and the ports of humidity_temp_frame_decoder.
module htfd_checker
	import htfd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	logic signed [14:0] temp_field;
	logic        [13:0] hum_field;
	logic        [1:0]  status_field;

	assign temp_field   = m_tdata[16:2];
	assign hum_field    = m_tdata[30:17];
	assign status_field = m_tdata[1:0];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result request changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status_field == STATUS_OK || status_field == STATUS_TEMP_CRC
			|| status_field == STATUS_HUM_CRC))
		else $error("undefined status code");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(temp_field) >= TEMP_MIN_CENTI && int'(temp_field) <= TEMP_MAX_CENTI))
		else $error("temperature out of range");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hum_field <= HUM_SPAN_CENTI && m_tdata[31] == 1'b0))
		else $error("humidity out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* test/tb_top.sv */
// Self-checking testbench for humidity_temp_frame_decoder: sends frame bytes and checks every
// decoded reading against a behavioural model of the CRC check and the scaling.
// Depends on htfd_pkg and the RTL top level.
module tb_top;
	import htfd_pkg::*;

	typedef struct packed {
		status_t           status;
		logic signed [14:0] temp_centi;
		logic [13:0]       hum_centi;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        s_tuser;   // [0] frame_start
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [1:0] status, [16:2] temperature_centi, [30:17] humidity_centi

	reading_t           readings_due[$];
	int                 mismatches;
	bit                 calm;

	logic [2:0]         frame_pos;
	logic [7:0]         crc_acc;
	logic [15:0]        raw_temp;
	logic [15:0]        raw_hum;
	logic               temp_bad;
	logic signed [14:0] last_temp;
	logic [13:0]        last_hum;

	reading_t           got;
	reading_t           due;

	humidity_temp_frame_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL humidity_temp_frame_decoder");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 40) begin
			$display("mismatch: %s", what);
		end
		mismatches++;
	endtask

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		repeat (8) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] crc_of_word(input logic [15:0] w);
		return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
	endfunction

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// advance the frame model by one accepted byte
	task automatic decode_rx_byte(input logic [7:0] b, input logic first);
		logic [2:0] pos;
		reading_t   r;
		pos = (first || frame_pos > POS_LAST) ? 3'd0 : frame_pos;
		case (pos)
			3'd0: begin
				raw_temp = {b, 8'h00};
				crc_acc  = crc_step(CRC_INIT, b);
			end
			3'd1: begin
				raw_temp[7:0] = b;
				crc_acc       = crc_step(crc_acc, b);
			end
			3'd2: begin
				temp_bad = (b != crc_acc);
				crc_acc  = CRC_INIT;
			end
			3'd3: begin
				raw_hum = {b, 8'h00};
				crc_acc = crc_step(CRC_INIT, b);
			end
			3'd4: begin
				raw_hum[7:0] = b;
				crc_acc      = crc_step(crc_acc, b);
			end
			default: ;
		endcase
		if (pos != POS_LAST) begin
			frame_pos = pos + 3'd1;
		end else begin
			if (temp_bad) begin
				r.status = STATUS_TEMP_CRC;
			end else if (b != crc_acc) begin
				r.status = STATUS_HUM_CRC;
			end else begin
				r.status  = STATUS_OK;
				last_temp = 15'(int'(TEMP_SPAN_CENTI) * int'(raw_temp) / int'(FULL_SCALE)
					- int'(TEMP_OFFSET_CENTI));
				last_hum  = 14'(int'(HUM_SPAN_CENTI) * int'(raw_hum) / int'(FULL_SCALE));
			end
			r.temp_centi = last_temp;
			r.hum_centi  = last_hum;
			readings_due.push_back(r);
			frame_pos = 3'd0;
			crc_acc   = CRC_INIT;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic first);
		logic ok;
		if (!calm && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		decode_rx_byte(b, first);
	endtask

	// corrupt[0] spoils the temperature CRC, corrupt[1] the humidity CRC
	task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
			input logic [1:0] corrupt, input logic first, input int unsigned nbytes);
		logic [7:0] frame [6];
		frame[0] = t_raw[15:8];
		frame[1] = t_raw[7:0];
		frame[2] = crc_of_word(t_raw) ^ (corrupt[0] ? 8'($urandom_range(1, 255)) : 8'h00);
		frame[3] = h_raw[15:8];
		frame[4] = h_raw[7:0];
		frame[5] = crc_of_word(h_raw) ^ (corrupt[1] ? 8'($urandom_range(1, 255)) : 8'h00);
		for (int i = 0; i < nbytes; i++) begin
			send_byte(frame[i], (i == 0) ? first : 1'b0);
		end
	endtask

	task automatic test_directed();
		send_frame(16'hFFFF, 16'hFFFF, 2'b00, 1'b1, 6);
		send_frame(16'h0000, 16'h0000, 2'b00, 1'b0, 6);
		send_frame(16'hA5C3, 16'h3C5A, 2'b00, 1'b1, 2);
		send_frame(16'h8000, 16'h1234, 2'b11, 1'b1, 6);
		send_frame(16'h6666, 16'hBEEF, 2'b10, 1'b1, 6);
	endtask

	task automatic test_random_frames(input int unsigned frames);
		logic [1:0] corrupt;
		logic       first;
		repeat (frames) begin
			case ($urandom_range(9))
				7: corrupt = 2'b01;
				8: corrupt = 2'b10;
				9: corrupt = 2'b11;
				default: corrupt = 2'b00;
			endcase
			first = (frame_pos == 3'd0) ? 1'($urandom_range(1)) : 1'b1;
			send_frame(pick_raw(), pick_raw(), corrupt, first, 6);
		end
	endtask

	task automatic test_broken_frames(input int unsigned rounds);
		repeat (rounds) begin
			send_frame(pick_raw(), pick_raw(), 2'($urandom_range(3)), 1'b1,
				$urandom_range(1, 5));
			repeat ($urandom_range(0, 3)) begin
				send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
			end
		end
	endtask

	task automatic test_back_to_back(input int unsigned frames);
		calm = 1'b1;
		test_random_frames(frames);
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 26);
	end

	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.status     = status_t'(m_tdata[1:0]);
			got.temp_centi = m_tdata[16:2];
			got.hum_centi  = m_tdata[30:17];
			if (readings_due.size() == 0) begin
				report_mismatch($sformatf("unexpected reading %h", m_tdata));
			end else begin
				due = readings_due.pop_front();
				if (got.status !== due.status) begin
					report_mismatch($sformatf("status %0d, want %0d", got.status, due.status));
				end
				if (got.temp_centi !== due.temp_centi) begin
					report_mismatch($sformatf("temperature %0d, want %0d",
						got.temp_centi, due.temp_centi));
				end
				if (got.hum_centi !== due.hum_centi) begin
					report_mismatch($sformatf("humidity %0d, want %0d",
						got.hum_centi, due.hum_centi));
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		calm       = 1'b0;
		frame_pos  = 3'd0;
		crc_acc    = CRC_INIT;
		raw_temp   = '0;
		raw_hum    = '0;
		temp_bad   = 1'b0;
		last_temp  = '0;
		last_hum   = '0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random_frames(125);
		test_broken_frames(60);
		test_back_to_back(25);
		test_random_frames(20);

		s_tvalid <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (readings_due.size() != 0) begin
			report_mismatch($sformatf("%0d readings never arrived", readings_due.size()));
		end

		if (mismatches == 0) begin
			$display("PASS humidity_temp_frame_decoder");
		end else begin
			$display("FAIL humidity_temp_frame_decoder");
		end
		$finish;
	end

endmodule

/* humidity_temp_frame_decoder.f */
rtl/htfd_pkg.sv
rtl/humidity_temp_frame_decoder.sv
rtl/htfd_checker.sv
test/tb_top.sv
